// ===== rtl/dag_shortest_path_assert.svh =====
// Assertion macros for the shortest-path block.
// Included by rtl/dag_shortest_path.sv; no other dependencies.
`ifndef DAG_SHORTEST_PATH_ASSERT_SVH
`define DAG_SHORTEST_PATH_ASSERT_SVH
`ifndef ASSERT_OFF
`define DSP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define DSP_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: label");
`else
`define DSP_ASSERT(label, clk, rst, prop)
`define DSP_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== rtl/dsp_pkg.sv =====
// Shared types and constants for the shortest-path block.
// No dependencies.
package dsp_pkg;
  localparam int DIST_BITS = 22;
  localparam int WEIGHT_BITS = 16;
  typedef logic signed [DIST_BITS-1:0] dist_t;
  localparam dist_t DIST_MAX = dist_t'(2097151);
  localparam dist_t DIST_MIN = dist_t'(-2097152);
  localparam dist_t DIST_NONE = dist_t'(-1);
endpackage

// ===== rtl/dag_shortest_path.sv =====
// Top level of the DAG shortest-path block.
// Depends on dsp_pkg and dag_shortest_path_assert.svh.
// Edge words load at one per cycle while in_stall is low into an edge
// table (MAX_EDGES deep). A word marked last_edge starts the solve: a
// depth-first walk with an explicit stack, then relaxation in reverse
// finishing order, then one result word per node in ascending order. The
// edge table, stack, order and distance stores all have one registered read
// port, so the walk handles each table entry that a node scans in a read
// state and a check state, and each pop in a further wait state. Relaxation
// reads each reached node's distance, then each entry in read, check and
// update states. Results wait on out_stall. in stall is high from the last
// word until the final result is taken.
`include "dag_shortest_path_assert.svh"
module dag_shortest_path
  import dsp_pkg::*;
#(
  parameter int MAX_NODES   = 64,
  parameter int MAX_EDGES   = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [6:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [5:0]           from_node,
  input  logic [5:0]           to_node,
  input  logic signed [15:0]   weight,
  input  logic                 has_edge,
  input  logic                 last_edge,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [5:0]           node_index,
  output logic signed [21:0]   distance,
  output logic                 reachable,
  output logic                 last_result
);
  localparam int EW = $clog2(MAX_EDGES+1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NW = $clog2(MAX_NODES);
  localparam int SW = $clog2(MAX_NODES+1);

  localparam logic [3:0] S_LOAD = 4'd0, S_WROOT = 4'd1, S_WRD = 4'd2,
    S_WCHK = 4'd3, S_WPOP = 4'd4, S_RINIT = 4'd5, S_RPICK = 4'd6,
    S_RTOP = 4'd7, S_RDU = 4'd8, S_RRD = 4'd9, S_RCHK = 4'd10,
    S_RUPD = 4'd11, S_ORD = 4'd12, S_OUT = 4'd13;

  logic [3:0] state;
  logic [6:0] node_count;
  logic [5:0] e_src [MAX_EDGES];
  logic [5:0] e_tgt [MAX_EDGES];
  logic signed [WEIGHT_BITS-1:0] e_wt [MAX_EDGES];
  logic [EW-1:0] edges_loaded;
  logic [5:0] rd_src, rd_tgt;
  logic signed [WEIGHT_BITS-1:0] rd_wt;
  logic [AW-1:0] rd_addr;
  logic [MAX_NODES-1:0] visited, reached;
  logic [5:0] topo [MAX_NODES];
  logic [5:0] topo_rd;
  logic [5:0] stk_node [MAX_NODES];
  logic [EW-1:0] stk_next [MAX_NODES];
  logic [5:0] stk_rd_node;
  logic [EW-1:0] stk_rd_next;
  logic [5:0] top_node;
  dist_t node_dist [MAX_NODES];
  dist_t dist_rd;
  logic [NW-1:0] dist_addr;
  logic [SW-1:0] sp, done, k;
  logic [6:0] root;
  logic [EW-1:0] ei;
  logic [5:0] u;
  dist_t du, cand;
  logic [6:0] n_use;
  logic signed [DIST_BITS:0] sum;

  assign n_use = (node_count == 7'd0) ? 7'd1 :
                 (node_count > 7'(MAX_NODES)) ? 7'(MAX_NODES) : node_count;
  assign cfg_ready = (state == S_LOAD);
  assign in_stall  = (state != S_LOAD);
  assign sum = (DIST_BITS+1)'(du) + (DIST_BITS+1)'(rd_wt);
  assign cand = (sum > (DIST_BITS+1)'(DIST_MAX)) ? DIST_MAX :
                (sum < (DIST_BITS+1)'(DIST_MIN)) ? DIST_MIN : dist_t'(sum);

  always_ff @(posedge clk) begin
    if (state == S_LOAD && in_valid && has_edge && edges_loaded < EW'(MAX_EDGES)) begin
      e_src[edges_loaded[AW-1:0]] <= from_node;
      e_tgt[edges_loaded[AW-1:0]] <= to_node;
      e_wt[edges_loaded[AW-1:0]]  <= WEIGHT_BITS'(weight);
    end
    rd_src <= e_src[rd_addr];
    rd_tgt <= e_tgt[rd_addr];
    rd_wt  <= e_wt[rd_addr];
    topo_rd <= topo[NW'(k - 1'b1)];
    stk_rd_node <= stk_node[NW'(sp - SW'(2))];
    stk_rd_next <= stk_next[NW'(sp - SW'(2))];
    dist_rd <= node_dist[dist_addr];
  end

  always_comb begin
    rd_addr = ei[AW-1:0];
  end

  always_comb begin
    unique case (state)
      S_RTOP:  dist_addr = topo_rd[NW-1:0];
      S_RCHK:  dist_addr = rd_tgt[NW-1:0];
      default: dist_addr = k[NW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      node_count <= 7'd64;
      edges_loaded <= '0;
      out_valid <= 1'b0;
      visited <= '0;
      reached <= '0;
      sp <= '0;
      k <= '0;
    end else begin
      if (cfg_valid && cfg_ready) node_count <= cfg_data;
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (has_edge && edges_loaded < EW'(MAX_EDGES)) edges_loaded <= edges_loaded + 1'b1;
            if (last_edge) begin
              visited <= '0; root <= '0; done <= '0; state <= S_WROOT;
            end
          end
        end
        S_WROOT: begin
          if (root >= n_use) state <= S_RINIT;
          else if (visited[root[NW-1:0]]) root <= root + 1'b1;
          else begin
            visited[root[NW-1:0]] <= 1'b1;
            top_node <= 6'(root);
            sp <= SW'(1); ei <= '0; root <= root + 1'b1;
            state <= S_WRD;
          end
        end
        S_WRD: begin
          if (ei >= edges_loaded) begin
            if (done < SW'(MAX_NODES)) begin
              topo[done[NW-1:0]] <= top_node; done <= done + 1'b1;
            end
            sp <= sp - 1'b1;
            if (sp == SW'(1)) state <= S_WROOT;
            else begin
              top_node <= stk_rd_node; ei <= stk_rd_next; state <= S_WPOP;
            end
          end else state <= S_WCHK;
        end
        S_WCHK: begin
          if (rd_src == top_node && 7'(rd_tgt) < n_use) begin
            if (!visited[rd_tgt[NW-1:0]] && sp < SW'(MAX_NODES)) begin
              visited[rd_tgt[NW-1:0]] <= 1'b1;
              stk_node[NW'(sp - 1'b1)] <= top_node;
              stk_next[NW'(sp - 1'b1)] <= ei + 1'b1;
              top_node <= rd_tgt;
              sp <= sp + 1'b1; ei <= '0;
            end else ei <= ei + 1'b1;
          end else ei <= ei + 1'b1;
          state <= S_WRD;
        end
        S_WPOP: begin
          // stack read port catches up with the new top
          state <= S_WRD;
        end
        S_RINIT: begin
          reached <= MAX_NODES'(1);
          node_dist[0] <= '0;
          k <= done; state <= S_RPICK;
        end
        S_RPICK: begin
          if (k == '0) state <= S_ORD;
          else begin k <= k - 1'b1; state <= S_RTOP; end
        end
        S_RTOP: begin
          if (7'(topo_rd) >= n_use || !reached[topo_rd[NW-1:0]]) state <= S_RPICK;
          else begin u <= topo_rd; ei <= '0; state <= S_RDU; end
        end
        S_RDU: begin
          du <= dist_rd; state <= S_RRD;
        end
        S_RRD: begin
          if (ei >= edges_loaded) state <= S_RPICK;
          else state <= S_RCHK;
        end
        S_RCHK: begin
          state <= S_RUPD;
        end
        S_RUPD: begin
          if (rd_src == u && 7'(rd_tgt) < n_use &&
              (!reached[rd_tgt[NW-1:0]] || cand < dist_rd)) begin
            node_dist[rd_tgt[NW-1:0]] <= cand; reached[rd_tgt[NW-1:0]] <= 1'b1;
            if (rd_tgt == u) du <= cand;
          end
          ei <= ei + 1'b1; state <= S_RRD;
        end
        S_ORD: begin
          out_valid <= 1'b1; state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (7'(k) + 7'd1 == n_use) begin
              edges_loaded <= '0; state <= S_LOAD;
            end else begin
              k <= k + 1'b1; state <= S_ORD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign node_index  = 6'(k);
  assign reachable   = reached[k[NW-1:0]];
  assign distance    = reachable ? dist_rd : DIST_NONE;
  assign last_result = (7'(k) + 7'd1 == n_use);

  `DSP_ASSERT(a_out_only_in_out, clk, rst, out_valid |-> state == S_OUT)
  `DSP_ASSERT(a_sp_bound, clk, rst, sp <= SW'(MAX_NODES))
  `DSP_ASSERT(a_edges_bound, clk, rst, edges_loaded <= EW'(MAX_EDGES))
  `DSP_ASSERT(a_node0_reached, clk, rst, state == S_OUT |-> reached[0])
endmodule
